FILE: sv/cffa_pkg.sv
// Shared constants, control word type and microcode table of the next-fit allocator.
package cffa_pkg;

   // Fixed field widths of the request and response words
   localparam int ADDR_W  = 12;
   localparam int BYTES_W = 16;
   localparam int ST_W    = 2;

   // Parameter defaults
   localparam int ARENA_WORDS_DEF = 4096;
   localparam int WORD_BYTES_DEF  = 4;
   localparam int GROW_WORDS_DEF  = 256;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
   localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

   localparam int PC_W  = 5;
   localparam int UOP_W = 5;
   localparam int BR_W  = 5;

   // Datapath micro-operations
   localparam logic [UOP_W-1:0] U_NOP     = 5'd0;
   localparam logic [UOP_W-1:0] U_CLR     = 5'd1;
   localparam logic [UOP_W-1:0] U_INIT0   = 5'd2;
   localparam logic [UOP_W-1:0] U_INIT1   = 5'd3;
   localparam logic [UOP_W-1:0] U_EMIT    = 5'd4;
   localparam logic [UOP_W-1:0] U_IDLE    = 5'd5;
   localparam logic [UOP_W-1:0] U_MUL     = 5'd6;
   localparam logic [UOP_W-1:0] U_START   = 5'd7;
   localparam logic [UOP_W-1:0] U_RDP     = 5'd8;
   localparam logic [UOP_W-1:0] U_LDPH    = 5'd9;
   localparam logic [UOP_W-1:0] U_RDQ     = 5'd10;
   localparam logic [UOP_W-1:0] U_MERGE   = 5'd11;
   localparam logic [UOP_W-1:0] U_ADV     = 5'd12;
   localparam logic [UOP_W-1:0] U_GQUOT   = 5'd13;
   localparam logic [UOP_W-1:0] U_GREM    = 5'd14;
   localparam logic [UOP_W-1:0] U_GROWSUM = 5'd15;
   localparam logic [UOP_W-1:0] U_GROWLO  = 5'd16;
   localparam logic [UOP_W-1:0] U_GROWMID = 5'd17;
   localparam logic [UOP_W-1:0] U_GROWHI  = 5'd18;
   localparam logic [UOP_W-1:0] U_SPLIT   = 5'd19;
   localparam logic [UOP_W-1:0] U_TAKE    = 5'd20;
   localparam logic [UOP_W-1:0] U_NOMEM   = 5'd21;
   localparam logic [UOP_W-1:0] U_FRD     = 5'd22;
   localparam logic [UOP_W-1:0] U_FWR     = 5'd23;
   localparam logic [UOP_W-1:0] U_BADFREE = 5'd24;

   // Branch conditions
   localparam logic [BR_W-1:0] B_NEVER        = 5'd0;
   localparam logic [BR_W-1:0] B_ALWAYS       = 5'd1;
   localparam logic [BR_W-1:0] B_NO_ACCEPT    = 5'd2;
   localparam logic [BR_W-1:0] B_FREE_OP      = 5'd3;
   localparam logic [BR_W-1:0] B_CNT_NOT_LAST = 5'd4;
   localparam logic [BR_W-1:0] B_PBUSY        = 5'd5;
   localparam logic [BR_W-1:0] B_QBAD         = 5'd6;
   localparam logic [BR_W-1:0] B_QBUSY        = 5'd7;
   localparam logic [BR_W-1:0] B_NQBAD        = 5'd8;
   localparam logic [BR_W-1:0] B_FITS         = 5'd9;
   localparam logic [BR_W-1:0] B_ADV_BAD      = 5'd10;
   localparam logic [BR_W-1:0] B_CONT         = 5'd11;
   localparam logic [BR_W-1:0] B_NTOP_OVF     = 5'd12;
   localparam logic [BR_W-1:0] B_FADDR_BAD    = 5'd13;
   localparam logic [BR_W-1:0] B_FHDR_BAD     = 5'd14;
   localparam logic [BR_W-1:0] B_OUT_BUSY     = 5'd15;

   // Program steps
   localparam logic [PC_W-1:0] S_CLR   = 5'd0;
   localparam logic [PC_W-1:0] S_INIT0 = 5'd1;
   localparam logic [PC_W-1:0] S_INIT1 = 5'd2;
   localparam logic [PC_W-1:0] S_EMIT  = 5'd3;
   localparam logic [PC_W-1:0] S_IDLE  = 5'd4;
   localparam logic [PC_W-1:0] S_DISP  = 5'd5;
   localparam logic [PC_W-1:0] S_A0    = 5'd6;
   localparam logic [PC_W-1:0] S_A1    = 5'd7;
   localparam logic [PC_W-1:0] S_LT    = 5'd8;
   localparam logic [PC_W-1:0] S_MG0   = 5'd9;
   localparam logic [PC_W-1:0] S_MG1   = 5'd10;
   localparam logic [PC_W-1:0] S_MG2   = 5'd11;
   localparam logic [PC_W-1:0] S_MG3   = 5'd12;
   localparam logic [PC_W-1:0] S_FIT   = 5'd13;
   localparam logic [PC_W-1:0] S_ADV   = 5'd14;
   localparam logic [PC_W-1:0] S_ADV2  = 5'd15;
   localparam logic [PC_W-1:0] S_G0    = 5'd16;
   localparam logic [PC_W-1:0] S_G1    = 5'd17;
   localparam logic [PC_W-1:0] S_G2    = 5'd18;
   localparam logic [PC_W-1:0] S_G3    = 5'd19;
   localparam logic [PC_W-1:0] S_G4    = 5'd20;
   localparam logic [PC_W-1:0] S_G5    = 5'd21;
   localparam logic [PC_W-1:0] S_G6    = 5'd22;
   localparam logic [PC_W-1:0] S_FOUND = 5'd23;
   localparam logic [PC_W-1:0] S_TAKE  = 5'd24;
   localparam logic [PC_W-1:0] S_NOMEM = 5'd25;
   localparam logic [PC_W-1:0] S_FR0   = 5'd26;
   localparam logic [PC_W-1:0] S_FR1   = 5'd27;
   localparam logic [PC_W-1:0] S_FR2   = 5'd28;
   localparam logic [PC_W-1:0] S_BADF  = 5'd29;

   typedef struct packed {
      logic [UOP_W-1:0] uop;
      logic [BR_W-1:0]  br;
      logic [PC_W-1:0]  tgt;
   } ucode_type;

   // Control store: micro-op, branch condition, branch target.
   // A step whose condition fails falls through to the next step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         S_CLR:   w = '{U_CLR,     B_CNT_NOT_LAST, S_CLR};
         S_INIT0: w = '{U_INIT0,   B_NEVER,        S_IDLE};
         S_INIT1: w = '{U_INIT1,   B_ALWAYS,       S_IDLE};
         S_EMIT:  w = '{U_EMIT,    B_OUT_BUSY,     S_EMIT};
         S_IDLE:  w = '{U_IDLE,    B_NO_ACCEPT,    S_IDLE};
         S_DISP:  w = '{U_MUL,     B_FREE_OP,      S_FR0};
         S_A0:    w = '{U_START,   B_NEVER,        S_IDLE};
         S_A1:    w = '{U_RDP,     B_NEVER,        S_IDLE};
         S_LT:    w = '{U_LDPH,    B_PBUSY,        S_ADV};
         S_MG0:   w = '{U_RDQ,     B_QBAD,         S_NOMEM};
         S_MG1:   w = '{U_NOP,     B_QBUSY,        S_FIT};
         S_MG2:   w = '{U_NOP,     B_NQBAD,        S_NOMEM};
         S_MG3:   w = '{U_MERGE,   B_ALWAYS,       S_MG0};
         S_FIT:   w = '{U_NOP,     B_FITS,         S_FOUND};
         S_ADV:   w = '{U_ADV,     B_ADV_BAD,      S_NOMEM};
         S_ADV2:  w = '{U_NOP,     B_CONT,         S_LT};
         S_G0:    w = '{U_GQUOT,   B_NEVER,        S_IDLE};
         S_G1:    w = '{U_GREM,    B_NEVER,        S_IDLE};
         S_G2:    w = '{U_GROWSUM, B_NEVER,        S_IDLE};
         S_G3:    w = '{U_NOP,     B_NTOP_OVF,     S_NOMEM};
         S_G4:    w = '{U_GROWLO,  B_NEVER,        S_IDLE};
         S_G5:    w = '{U_GROWMID, B_NEVER,        S_IDLE};
         S_G6:    w = '{U_GROWHI,  B_ALWAYS,       S_LT};
         S_FOUND: w = '{U_SPLIT,   B_NEVER,        S_IDLE};
         S_TAKE:  w = '{U_TAKE,    B_ALWAYS,       S_EMIT};
         S_NOMEM: w = '{U_NOMEM,   B_ALWAYS,       S_EMIT};
         S_FR0:   w = '{U_FRD,     B_FADDR_BAD,    S_BADF};
         S_FR1:   w = '{U_NOP,     B_FHDR_BAD,     S_BADF};
         S_FR2:   w = '{U_FWR,     B_ALWAYS,       S_EMIT};
         S_BADF:  w = '{U_BADFREE, B_ALWAYS,       S_EMIT};
         default: w = '{U_NOP,     B_ALWAYS,       S_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: sv/cffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/circular_first_fit_allocator.sv
// Next-fit heap allocator with busy-bit block headers, run by a microcoded sequencer.
//
// Each request word is an allocate (op 0, request_bytes) or a free (op 1, free_address);
// each gives exactly one response word (granted_address, status). After reset the block
// clears its header RAM, one word a cycle, and takes no request until it has also written
// the two sentinel headers. All work goes through the header RAM (one write port, one read
// port, registered read), so time per request is set by the headers it touches: a free
// reads and checks one header and rewrites it if valid; an allocate sizes the block, then
// scans, stepping over busy blocks and merging each run of free blocks before testing it
// for a fit, plus a growth step each time the scan wraps twice without a fit. The response
// sits in an output register; the next request is taken once the response word is loaded.
module circular_first_fit_allocator #(
   parameter int ARENA_WORDS = cffa_pkg::ARENA_WORDS_DEF,
   parameter int WORD_BYTES  = cffa_pkg::WORD_BYTES_DEF,
   parameter int GROW_WORDS  = cffa_pkg::GROW_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [cffa_pkg::BYTES_W-1:0] req_request_bytes,
   input  logic [cffa_pkg::ADDR_W-1:0]  req_free_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cffa_pkg::ADDR_W-1:0]  rsp_granted_address,
   output logic [cffa_pkg::ST_W-1:0]    rsp_status
);
   import cffa_pkg::*;

   localparam int AW  = $clog2(ARENA_WORDS);
   localparam int HW  = AW + 1;
   // block size in words: nw = (bytes + 2*WORD_BYTES - 1) / WORD_BYTES
   localparam int X_W = $clog2((1 << BYTES_W) + 2 * WORD_BYTES);
   localparam int NW_W = X_W;
   localparam int RS   = X_W + 4;
   localparam longint RECIP = ((longint'(1) << RS) + WORD_BYTES - 1) / WORD_BYTES;
   localparam int P_W  = X_W + RS + 1;
   // growth: y = nw + GROW_WORDS, grow = y - (y mod GROW_WORDS)
   localparam int Y_W  = $clog2((1 << NW_W) + GROW_WORDS);
   localparam int G_W  = $clog2(GROW_WORDS + 1);
   // y / GROW_WORDS by reciprocal multiplication, exact over the whole range of y
   localparam int GS   = Y_W + G_W;
   localparam longint GRECIP = ((longint'(1) << GS) + GROW_WORDS - 1) / GROW_WORDS;
   localparam int GP_W = Y_W + GS + 1;
   localparam int GM_W = Y_W + G_W;
   localparam int M1   = (AW + 1 > NW_W) ? AW + 1 : NW_W;
   localparam int M2   = (M1 > Y_W) ? M1 : Y_W;
   localparam int M3   = (M2 > ADDR_W) ? M2 : ADDR_W;
   localparam int XW   = M3 + 1;

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   ucode_type       cw;
   logic            take_br;

   // architectural state
   logic [AW-1:0] rover_ff, rover_in;
   logic [AW-1:0] top_ff, top_in;

   // request latch
   logic               op_ff, op_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [ADDR_W-1:0]  faddr_ff, faddr_in;

   // datapath
   logic [P_W-1:0]  prod_ff, prod_in;
   logic [NW_W-1:0] nw_ff, nw_in;
   logic [AW-1:0]   p_ff, p_in;
   logic [AW-1:0]   q_ff, q_in;
   logic [AW-1:0]   plink_ff, plink_in;
   logic [1:0]      wraps_ff, wraps_in;
   logic [Y_W-1:0]  dq_ff, dq_in;
   logic [G_W-1:0]  rem_ff, rem_in;
   logic [XW-1:0]   ntop_ff, ntop_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ST_W-1:0]   res_st_ff, res_st_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;

   // header RAM
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [HW-1:0] wr_data, rd_data;
   logic [AW-1:0] rd_link;
   logic          rd_busy;

   // helpers
   logic            req_accept;
   logic            out_busy;
   logic [X_W-1:0]  x_sum;
   logic [Y_W-1:0]  y_val;
   logic [XW-1:0]   r_x;
   logic [AW-1:0]   r_val;
   logic            adv_bad;
   logic            wrap_now;

   cffa_ram #(
      .WIDTH (HW),
      .DEPTH (ARENA_WORDS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_link = rd_data[HW-1:1];
   assign rd_busy = rd_data[0];

   assign req_ready  = (pc_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_st_ff;

   assign cw = ucode_rom(pc_ff);

   assign x_sum = X_W'(bytes_ff) + X_W'(2 * WORD_BYTES - 1);
   assign y_val = Y_W'(nw_ff) + Y_W'(GROW_WORDS);
   assign r_x   = XW'(p_ff) + XW'(nw_ff);
   assign r_val = r_x[AW-1:0];

   // the only backward link allowed is the closing one from the top header to word 0
   assign wrap_now = (plink_ff <= p_ff) && (p_ff == top_ff) && (plink_ff == '0);
   assign adv_bad  = (plink_ff > p_ff) ? (plink_ff > top_ff) : !wrap_now;

   always_comb begin
      unique case (cw.br)
         B_NEVER:        take_br = 1'b0;
         B_ALWAYS:       take_br = 1'b1;
         B_NO_ACCEPT:    take_br = !req_accept;
         B_FREE_OP:      take_br = (op_ff == OP_FREE);
         B_CNT_NOT_LAST: take_br = (cnt_ff != AW'(ARENA_WORDS - 1));
         B_PBUSY:        take_br = rd_busy;
         B_QBAD:         take_br = (plink_ff <= p_ff) || (plink_ff > top_ff);
         B_QBUSY:        take_br = rd_busy;
         B_NQBAD:        take_br = (rd_link <= q_ff) || (rd_link > top_ff);
         B_FITS:         take_br = (XW'(q_ff) >= r_x);
         B_ADV_BAD:      take_br = adv_bad;
         B_CONT:         take_br = (p_ff > q_ff) || (wraps_ff == 2'd1);
         B_NTOP_OVF:     take_br = (ntop_ff >= XW'(ARENA_WORDS));
         B_FADDR_BAD:    take_br = (faddr_ff == '0) || (XW'(faddr_ff) > XW'(top_ff));
         B_FHDR_BAD:     take_br = !rd_busy || (rd_link <= p_ff) || (rd_link > top_ff);
         B_OUT_BUSY:     take_br = out_busy;
         default:        take_br = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = take_br ? cw.tgt : pc_ff + 1'b1;
      cnt_in       = cnt_ff;
      rover_in     = rover_ff;
      top_in       = top_ff;
      op_in        = op_ff;
      bytes_in     = bytes_ff;
      faddr_in     = faddr_ff;
      prod_in      = prod_ff;
      nw_in        = nw_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      plink_in     = plink_ff;
      wraps_in     = wraps_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      ntop_in      = ntop_ff;
      res_addr_in  = res_addr_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      wr_en        = 1'b0;
      wr_addr      = p_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = p_ff;

      unique case (cw.uop)
         U_NOP: begin
         end
         U_CLR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + 1'b1;
         end
         U_INIT0: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {AW'(1), 1'b1};
         end
         U_INIT1: begin
            wr_en   = 1'b1;
            wr_addr = AW'(1);
            wr_data = {AW'(0), 1'b1};
         end
         U_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_st_in    = res_st_ff;
            end
         end
         U_IDLE: begin
            if (req_accept) begin
               op_in    = req_op;
               bytes_in = req_request_bytes;
               faddr_in = req_free_address;
            end
         end
         U_MUL: begin
            prod_in = P_W'(x_sum) * P_W'(RECIP);
         end
         U_START: begin
            nw_in    = NW_W'(prod_ff >> RS);
            p_in     = (rover_ff > top_ff) ? '0 : rover_ff;
            wraps_in = 2'd0;
         end
         U_RDP: begin
            rd_en   = 1'b1;
            rd_addr = p_ff;
         end
         U_LDPH: begin
            plink_in = rd_link;
         end
         U_RDQ: begin
            q_in    = plink_ff;
            rd_en   = 1'b1;
            rd_addr = plink_ff;
         end
         U_MERGE: begin
            // absorb the free block at q into p
            wr_en    = 1'b1;
            wr_addr  = p_ff;
            wr_data  = {rd_link, 1'b0};
            plink_in = rd_link;
         end
         U_ADV: begin
            q_in    = p_ff;
            p_in    = plink_ff;
            rd_en   = 1'b1;
            rd_addr = plink_ff;
            if (wrap_now) begin
               wraps_in = wraps_ff + 2'd1;
            end
         end
         U_GQUOT: begin
            dq_in = Y_W'((GP_W'(y_val) * GP_W'(GRECIP)) >> GS);
         end
         U_GREM: begin
            rem_in = G_W'(y_val - Y_W'(GM_W'(dq_ff) * GM_W'(GROW_WORDS)));
         end
         U_GROWSUM: begin
            ntop_in = XW'(top_ff) + XW'(y_val - Y_W'(rem_ff));
         end
         U_GROWLO: begin
            wr_en   = 1'b1;
            wr_addr = top_ff;
            wr_data = {top_ff + 1'b1, 1'b0};
         end
         U_GROWMID: begin
            wr_en   = 1'b1;
            wr_addr = top_ff + 1'b1;
            wr_data = {ntop_ff[AW-1:0], 1'b0};
         end
         U_GROWHI: begin
            wr_en    = 1'b1;
            wr_addr  = ntop_ff[AW-1:0];
            wr_data  = {AW'(0), 1'b1};
            top_in   = ntop_ff[AW-1:0];
            p_in     = '0;
            wraps_in = 2'd0;
            rd_en    = 1'b1;
            rd_addr  = '0;
         end
         U_SPLIT: begin
            // leftover words become a free block of their own
            if (XW'(q_ff) > r_x) begin
               wr_en   = 1'b1;
               wr_addr = r_val;
               wr_data = {plink_ff, 1'b0};
            end
         end
         U_TAKE: begin
            wr_en       = 1'b1;
            wr_addr     = p_ff;
            wr_data     = {r_val, 1'b1};
            rover_in    = r_val;
            res_addr_in = ADDR_W'(XW'(p_ff) + XW'(1));
            res_st_in   = ST_OK;
         end
         U_NOMEM: begin
            res_addr_in = '0;
            res_st_in   = ST_NOMEM;
         end
         U_FRD: begin
            p_in    = AW'(XW'(faddr_ff) - XW'(1));
            rd_en   = 1'b1;
            rd_addr = AW'(XW'(faddr_ff) - XW'(1));
         end
         U_FWR: begin
            wr_en       = 1'b1;
            wr_addr     = p_ff;
            wr_data     = {rd_link, 1'b0};
            rover_in    = p_ff;
            res_addr_in = '0;
            res_st_in   = ST_OK;
         end
         U_BADFREE: begin
            res_addr_in = '0;
            res_st_in   = ST_BADFREE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_CLR;
         cnt_ff       <= '0;
         rover_ff     <= '0;
         top_ff       <= AW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rover_ff     <= rover_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bytes_ff    <= bytes_in;
      faddr_ff    <= faddr_in;
      prod_ff     <= prod_in;
      nw_ff       <= nw_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      plink_ff    <= plink_in;
      wraps_ff    <= wraps_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      ntop_ff     <= ntop_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the next-fit heap allocator: shadow heap, driver and monitor.
`timescale 1ns / 100ps

module testbench;
   import cffa_pkg::*;

   localparam int HEAP_WORDS   = ARENA_WORDS_DEF;
   localparam int HEAP_WBYTES  = WORD_BYTES_DEF;
   localparam int HEAP_GROW    = GROW_WORDS_DEF;
   localparam int RANDOM_ITEMS = 1300;
   // The header clear after reset walks the whole arena, and an allocate may walk the whole
   // list three times, so the run limit is set high.
   localparam int RUN_LIMIT    = 50_000_000;

   typedef struct packed {
      logic               pause;
      logic               op;
      logic [BYTES_W-1:0] nbytes;
      logic [ADDR_W-1:0]  faddr;
   } heap_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ST_W-1:0]   status;
   } heap_grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_op = OP_ALLOC;
   logic [BYTES_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0]   req_free_address = '0;
   logic                rsp_ready = 1'b0;
   wire                 req_ready;
   wire                 rsp_valid;
   wire [ADDR_W-1:0]    rsp_granted_address;
   wire [ST_W-1:0]      rsp_status;

   // shadow copy of the heap
   logic [ADDR_W-1:0]   heap_link [HEAP_WORDS];
   logic                heap_busy [HEAP_WORDS];
   int                  scan_start;
   int                  heap_top;

   heap_cmd_type        cmd_backlog [$];
   heap_grant_type      due_grants [$];
   int                  held_blocks [$];
   bit                  draining = 1'b0;
   int                  n_accepted = 0;
   int                  n_checked = 0;
   int                  err_count = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;
   int                  last_freed = 0;

   wire calm = (n_checked >= 700) && (n_checked < 900);

   circular_first_fit_allocator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

   initial forever #5 clock = ~clock;

   function automatic void shadow_reset();
      for (int i = 0; i < HEAP_WORDS; i++) begin
         heap_link[i] = '0;
         heap_busy[i] = 1'b0;
      end
      heap_link[0] = ADDR_W'(1);
      heap_busy[0] = 1'b1;
      heap_busy[1] = 1'b1;
      scan_start = 0;
      heap_top = 1;
   endfunction

   function automatic void shadow_alloc(input int nbytes, output logic [ADDR_W-1:0] addr,
                                        output logic [ST_W-1:0] st);
      int nw, p, q, nq, r, prev, wraps, grow, ntop;
      bit fit;
      nw = (nbytes + 2 * HEAP_WBYTES - 1) / HEAP_WBYTES;
      addr = '0;
      st = ST_NOMEM;
      fit = 1'b0;
      q = 0;
      p = scan_start;
      if (p > heap_top) p = 0;
      while (1) begin
         wraps = 0;
         while (1) begin
            if (!heap_busy[p]) begin
               // absorb the run of free blocks that follows p
               while (1) begin
                  q = int'(heap_link[p]);
                  if (q <= p || q > heap_top) return;
                  if (heap_busy[q]) break;
                  nq = int'(heap_link[q]);
                  if (nq <= q || nq > heap_top) return;
                  heap_link[p] = ADDR_W'(nq);
               end
               if (q >= p + nw) begin
                  fit = 1'b1;
                  break;
               end
            end
            prev = p;
            p = int'(heap_link[p]);
            if (p > prev) begin
               if (p > heap_top) return;
            end else if (prev != heap_top || p != 0) begin
               return;
            end else begin
               wraps++;
               if (wraps > 1) break;
            end
         end
         if (fit) break;
         grow = ((nw + HEAP_GROW) / HEAP_GROW) * HEAP_GROW;
         ntop = heap_top + grow;
         if (ntop >= HEAP_WORDS) return;
         heap_link[heap_top] = ADDR_W'(heap_top + 1);
         heap_busy[heap_top] = 1'b0;
         heap_link[heap_top + 1] = ADDR_W'(ntop);
         heap_busy[heap_top + 1] = 1'b0;
         heap_top = ntop;
         heap_link[ntop] = '0;
         heap_busy[ntop] = 1'b1;
         p = 0;
      end
      r = p + nw;
      if (q > r) begin
         heap_link[r] = heap_link[p];
         heap_busy[r] = 1'b0;
      end
      heap_link[p] = ADDR_W'(r);
      heap_busy[p] = 1'b1;
      scan_start = r;
      addr = ADDR_W'(p + 1);
      st = ST_OK;
   endfunction

   function automatic void shadow_free(input int a, output logic [ADDR_W-1:0] addr,
                                       output logic [ST_W-1:0] st);
      int h, nxt;
      addr = '0;
      st = ST_BADFREE;
      if (a == 0 || a > heap_top) return;
      h = a - 1;
      nxt = int'(heap_link[h]);
      if (!heap_busy[h] || nxt <= h || nxt > heap_top) return;
      heap_busy[h] = 1'b0;
      scan_start = h;
      st = ST_OK;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // driver: predicts on every accepted word, then offers the next one from the backlog
   always @(posedge clock) begin : sender
      heap_cmd_type      cmd;
      heap_grant_type    g;
      logic [ADDR_W-1:0] g_addr;
      logic [ST_W-1:0]   g_st;
      logic              go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_op == OP_FREE)
               shadow_free(int'(req_free_address), g_addr, g_st);
            else
               shadow_alloc(int'(req_request_bytes), g_addr, g_st);
            g.addr = g_addr;
            g.status = g_st;
            due_grants.push_back(g);
            if (req_op == OP_ALLOC && g_st == ST_OK) held_blocks.push_back(int'(g_addr));
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            go = 1'b0;
            if (draining && n_checked == n_accepted) draining = 1'b0;
            if (!draining && cmd_backlog.size() != 0 &&
                (calm || $urandom_range(99, 0) >= 30)) begin
               cmd = cmd_backlog.pop_front();
               if (cmd.pause) begin
                  draining = 1'b1;
               end else begin
                  go = 1'b1;
                  req_op <= cmd.op;
                  req_request_bytes <= cmd.nbytes;
                  req_free_address <= cmd.faddr;
               end
            end
            req_valid <= go;
         end
      end
   end

   // response side: random stalls plus one long hold-off that backs the block up
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && n_checked >= 300) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99, 0) >= 30);
         end
      end
   end

   always @(posedge clock) begin : monitor
      heap_grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked <= n_checked + 1;
         if (due_grants.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("word %0d: unexpected response, address %0d status %0d",
                        n_checked, rsp_granted_address, rsp_status);
         end else begin
            want = due_grants.pop_front();
            if (rsp_granted_address !== want.addr || rsp_status !== want.status) begin
               err_count++;
               if (err_count <= 10)
                  $display("word %0d: address exp %0d got %0d, status exp %0d got %0d",
                           n_checked, want.addr, rsp_granted_address,
                           want.status, rsp_status);
            end
         end
      end
   end

   task automatic push_cmd(input heap_cmd_type c);
      while (cmd_backlog.size() >= 2) @(negedge clock);
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_alloc(input int nbytes);
      heap_cmd_type c;
      c.pause = 1'b0;
      c.op = OP_ALLOC;
      c.nbytes = BYTES_W'(nbytes);
      c.faddr = ADDR_W'($urandom);
      push_cmd(c);
   endtask

   task automatic queue_free(input int a);
      heap_cmd_type c;
      c.pause = 1'b0;
      c.op = OP_FREE;
      c.nbytes = BYTES_W'($urandom);
      c.faddr = ADDR_W'(a);
      push_cmd(c);
   endtask

   // hold the sender until every word sent so far has been answered
   task automatic settle();
      heap_cmd_type c;
      c = '0;
      c.pause = 1'b1;
      push_cmd(c);
      @(negedge clock);
      while (cmd_backlog.size() != 0 || draining) @(negedge clock);
   endtask

   task automatic queue_random();
      int r, k, idx, nb;
      r = $urandom_range(99, 0);
      if (held_blocks.size() != 0 && (r < 40 || held_blocks.size() > 40)) begin
         idx = $urandom_range(held_blocks.size() - 1, 0);
         last_freed = held_blocks[idx];
         held_blocks.delete(idx);
         queue_free(last_freed);
      end else if (r < 46) begin
         // broken frees: double free, just above top, inside a block, anywhere
         k = $urandom_range(3, 0);
         if (k == 0)
            queue_free(last_freed);
         else if (k == 1)
            queue_free(heap_top + 1);
         else if (k == 2 && held_blocks.size() != 0)
            queue_free(held_blocks[$urandom_range(held_blocks.size() - 1, 0)] + 1);
         else
            queue_free($urandom_range(4095, 0));
      end else begin
         k = $urandom_range(99, 0);
         if (k < 70)
            nb = $urandom_range(96, 0);
         else if (k < 88)
            nb = $urandom_range(1024, 97);
         else if (k < 96)
            nb = $urandom_range(8000, 1025);
         else
            nb = $urandom_range(65535, 8001);
         queue_alloc(nb);
      end
   endtask

   initial begin : stimulus
      int a;
      shadow_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_free(1);       // low sentinel: busy with a forward link, so it is released
      queue_alloc(0);      // header-only block takes it back
      queue_free(0);
      queue_free(4095);
      queue_alloc(0);
      queue_alloc(1);
      queue_alloc(4);
      queue_alloc(5);
      queue_alloc(1016);   // 255 words: one granule of growth
      queue_alloc(1017);   // 256 words: two granules
      queue_alloc(65535);  // no growth can hold it
      queue_alloc(16000);  // growth would run past the arena
      settle();
      a = held_blocks[1];
      held_blocks.delete(1);
      queue_free(a);
      queue_free(a);       // double free
      queue_free(held_blocks[held_blocks.size() - 1] + 1);
      queue_alloc(8000);
      queue_alloc(4000);
      settle();
      while (held_blocks.size() != 0) queue_free(held_blocks.pop_front());
      queue_alloc(8);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) settle();
         queue_random();
      end
      settle();
      repeat (100) @(negedge clock);
      if (err_count == 0 && due_grants.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
